// ----- rtl/olad_pkg.sv -----
// Shared constants, codes and control types for the ordered list core.
`default_nettype none
package olad_pkg;

  // Storage geometry.
  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed result field widths.
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 4;

  // Request kind codes.
  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_DELETE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SEARCH_RD,
    S_SEARCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_RESP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;       // capture request, clear index
    logic    rd_en;      // read store into read register
    logic    rd_next;    // read at index + 1 instead of index
    logic    wr_append;  // write key at tail, bump count
    logic    wr_shift;   // write read data at index
    logic    idx_inc;    // advance index
    logic    hit_save;   // remember index as result position
    logic    cnt_dec;    // drop one entry from count
    logic    res_we;     // capture result status
    status_e res_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic kind_del;
    logic full;
    logic empty;
    logic match;
    logic idx_last;
  } stat_t;

endpackage
`default_nettype wire

// ----- rtl/olad_dp.sv -----
// Datapath of the ordered list core: entry store, count, index and result registers.
`default_nettype none
module olad_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire olad_pkg::cmd_t                cmd_i,
  output olad_pkg::stat_t                    stat_o,
  input  wire logic                          kind_i,
  input  wire logic signed [31:0]            value_i,
  output logic [olad_pkg::STATUS_W-1:0]      status_o,
  output logic [olad_pkg::COUNT_W-1:0]       entry_count_o,
  output logic [olad_pkg::POS_W-1:0]         position_o,
  output logic                               now_empty_o
);
  import olad_pkg::*;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rdata_q;
  logic [DATA_W-1:0] key_q;
  logic              kind_q;
  logic [IDX_W-1:0]  idx_q;
  logic [IDX_W-1:0]  pos_q;
  status_e           status_q;
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  count_d;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  tail_idx;
  logic [CNT_W-1:0]  idx_plus1;

  assign tail_idx  = count_q[IDX_W-1:0];
  assign idx_plus1 = CNT_W'(idx_q) + CNT_W'(1);
  assign rd_addr   = cmd_i.rd_next ? (idx_q + IDX_W'(1)) : idx_q;

  // Entry store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_append) begin
      mem[tail_idx] <= key_q;
    end else if (cmd_i.wr_shift) begin
      mem[idx_q] <= rdata_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Entry count.
  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_append) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Request, index and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= $unsigned(value_i);
      kind_q <= kind_i;
      idx_q  <= '0;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.wr_append) begin
      pos_q <= tail_idx;
    end else if (cmd_i.hit_save) begin
      pos_q <= idx_q;
    end else if (cmd_i.res_we && cmd_i.res_status != ST_OK) begin
      pos_q <= '0;
    end
    if (cmd_i.res_we) begin
      status_q <= cmd_i.res_status;
    end
  end

  // Status toward the controller.
  assign stat_o.kind_del = (kind_q == KIND_DELETE);
  assign stat_o.full     = (count_q >= CNT_W'(CAPACITY));
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.match    = (rdata_q == key_q);
  assign stat_o.idx_last = (idx_plus1 >= count_q);

  // Result fields, reduced to their port widths.
  assign status_o      = status_q;
  assign entry_count_o = COUNT_W'(32'(count_q));
  assign position_o    = POS_W'(32'(pos_q));
  assign now_empty_o   = (count_q == '0);

endmodule
`default_nettype wire

// ----- rtl/olad_ctrl.sv -----
// Controller of the ordered list core: sequences append, search and shift steps.
`default_nettype none
module olad_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  output logic                 done_o,
  output olad_pkg::cmd_t       cmd_o,
  input  wire olad_pkg::stat_t stat_i
);
  import olad_pkg::*;

  state_e state_q;
  state_e state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_status = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat_i.kind_del) begin
          cmd_o.res_we = 1'b1;
          if (stat_i.full) begin
            cmd_o.res_status = ST_FULL;
          end else begin
            cmd_o.wr_append  = 1'b1;
            cmd_o.res_status = ST_OK;
          end
          state_d = S_RESP;
        end else if (stat_i.empty) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_EMPTY;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SEARCH_CMP;
        end
      end
      S_SEARCH_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SEARCH_CMP;
      end
      S_SEARCH_CMP: begin
        if (stat_i.match) begin
          cmd_o.hit_save = 1'b1;
          state_d        = S_SHIFT_RD;
        end else if (stat_i.idx_last) begin
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_MISSING;
          state_d          = S_RESP;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_SEARCH_RD;
        end
      end
      S_SHIFT_RD: begin
        if (stat_i.idx_last) begin
          cmd_o.cnt_dec    = 1'b1;
          cmd_o.res_we     = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_RESP;
        end else begin
          cmd_o.rd_en   = 1'b1;
          cmd_o.rd_next = 1'b1;
          state_d       = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_SHIFT_RD;
      end
      S_RESP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_RESP);

endmodule
`default_nettype wire

// ----- rtl/ordered_list_append_delete_core.sv -----
// Top level of the ordered list core with append and delete by key.
// Usage:
//   A request is a transaction taken at a rising edge with start_i high and
//   busy_o low; kind_i selects append (0) or delete of the first equal
//   entry (1), value_i carries the value or key.
//   Each request gives one result, shown for a single cycle with done_o
//   high: status_o, entry_count_o, position_o and now_empty_o.
//   busy_o stays high from acceptance through the result cycle, so one
//   request is worked on at a time.
// Sequence:
//   An append, and a delete on an empty list, go from the check state
//   straight to the result state. A delete reads the entry store once per
//   entry, with a read state and a compare state for each entry examined
//   in the search and a read state and a write state for each later entry
//   moved down; the single read port of the store sets this pace.
// Reset:
//   Reset empties the list; the stored values need no clearing.
//   The receiver cannot stall; each result is taken in its strobe cycle.
`default_nettype none
module ordered_list_append_delete_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic                     kind_i,
  input  wire logic signed [31:0]       value_i,
  output logic                          done_o,
  output logic [olad_pkg::STATUS_W-1:0] status_o,
  output logic [olad_pkg::COUNT_W-1:0]  entry_count_o,
  output logic [olad_pkg::POS_W-1:0]    position_o,
  output logic                          now_empty_o
);
  import olad_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequencer.
  olad_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // Store and result registers.
  olad_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .status_o     (status_o),
    .entry_count_o(entry_count_o),
    .position_o   (position_o),
    .now_empty_o  (now_empty_o)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the ordered list core with append and delete by key.
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import olad_pkg::*;

  // Generous run limit in clock cycles, far above the slowest correct run.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1600;
  localparam int GAP_PCT = 13;

  // Expected result of one request.
  typedef struct {
    status_e              status;
    logic [COUNT_W-1:0]   count;
    logic [POS_W-1:0]     pos;
    logic                 empty;
  } list_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  kind_i;
  logic signed [31:0]    value_i;
  logic                  done_o;
  logic [STATUS_W-1:0]   status_o;
  logic [COUNT_W-1:0]    entry_count_o;
  logic [POS_W-1:0]      position_o;
  logic                  now_empty_o;

  // Shadow copy of the list contents and the results still to arrive.
  logic signed [DATA_W-1:0] shadow_list [CAPACITY];
  int                       shadow_cnt;
  list_result_t             pending_results [$];
  int                       err_cnt;
  int                       cycle_cnt;
  bit                       gaps_on;

  ordered_list_append_delete_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .kind_i        (kind_i),
    .value_i       (value_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o),
    .position_o    (position_o),
    .now_empty_o   (now_empty_o)
  );

  // Clock with a 12 ns period.
  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("[ordered_list_append_delete_core] ERROR");
      $finish;
    end
  end

  // Apply one request to the shadow list and return the result it should give.
  function automatic list_result_t apply_request(input logic kind,
                                                 input logic signed [DATA_W-1:0] key);
    list_result_t res;
    int           hit;
    hit = -1;
    res.status = ST_OK;
    res.pos = '0;
    if (kind == KIND_APPEND) begin
      if (shadow_cnt >= CAPACITY) begin
        res.status = ST_FULL;
      end else begin
        shadow_list[shadow_cnt] = key;
        res.pos = shadow_cnt[POS_W-1:0];
        shadow_cnt++;
      end
    end else if (shadow_cnt == 0) begin
      res.status = ST_EMPTY;
    end else begin
      // Search from the head for the first equal entry.
      for (int i = 0; i < shadow_cnt; i++) begin
        if (hit < 0 && shadow_list[i] == key) hit = i;
      end
      if (hit < 0) begin
        res.status = ST_MISSING;
      end else begin
        // Close the gap so the order is kept.
        for (int i = hit; i + 1 < shadow_cnt; i++) shadow_list[i] = shadow_list[i + 1];
        shadow_cnt--;
        res.pos = hit[POS_W-1:0];
      end
    end
    res.count = shadow_cnt[COUNT_W-1:0];
    res.empty = (shadow_cnt == 0);
    return res;
  endfunction

  // Values drawn half the time from a narrow range so duplicates and hits are common.
  function automatic logic signed [31:0] random_value();
    logic signed [31:0] v;
    if ($urandom_range(99) < 50) begin
      v = $urandom_range(7);
      v = v - 4;
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Delete keys: mostly a value held in the list, otherwise anything.
  function automatic logic signed [31:0] random_key();
    int r;
    r = $urandom_range(99);
    if (shadow_cnt > 0 && r < 65) return shadow_list[$urandom_range(shadow_cnt - 1)];
    return random_value();
  endfunction

  // Send one request transaction, with random idle cycles ahead of it while gaps are on.
  task automatic issue_request(input logic kind, input logic signed [31:0] value);
    @(negedge clk_i);
    while (gaps_on && $urandom_range(99) < GAP_PCT) begin
      start_i <= 1'b0;
      kind_i  <= 1'($urandom);
      value_i <= $urandom;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    kind_i  <= kind;
    value_i <= value;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    pending_results.push_back(apply_request(kind, value));
  endtask

  // Stop sending and wait until every expected result has arrived.
  task automatic drain_results();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Compare each result with the oldest expectation.
  always @(posedge clk_i) begin
    list_result_t exp_res;
    if (rst_ni && done_o !== 1'b0) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request waiting: status %0d count %0d pos %0d",
                 $time, status_o, entry_count_o, position_o);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (status_o !== exp_res.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_res.status, status_o);
          err_cnt++;
        end
        if (entry_count_o !== exp_res.count) begin
          $display("%0t: entry_count expected %0d actual %0d",
                   $time, exp_res.count, entry_count_o);
          err_cnt++;
        end
        if (position_o !== exp_res.pos) begin
          $display("%0t: position expected %0d actual %0d", $time, exp_res.pos, position_o);
          err_cnt++;
        end
        if (now_empty_o !== exp_res.empty) begin
          $display("%0t: now_empty expected %0b actual %0b",
                   $time, exp_res.empty, now_empty_o);
          err_cnt++;
        end
      end
    end
  end

  // Delete on a list that has never held anything.
  task automatic test_delete_empty();
    issue_request(KIND_DELETE, 32'sd0);
  endtask

  // Removing the only entry leaves the list empty and usable.
  task automatic test_delete_last_entry();
    issue_request(KIND_APPEND, 32'sd7);
    issue_request(KIND_DELETE, 32'sd7);
  endtask

  // Append the extreme values of the field.
  task automatic test_append_extremes();
    issue_request(KIND_APPEND, 32'sh8000_0000);
    issue_request(KIND_APPEND, 32'sh7fff_ffff);
    issue_request(KIND_APPEND, 32'sd0);
    issue_request(KIND_APPEND, -32'sd1);
  endtask

  // A key that is not held leaves the list alone.
  task automatic test_delete_missing();
    issue_request(KIND_DELETE, 32'sd1);
  endtask

  // Removing from the middle shifts the later entries down.
  task automatic test_delete_middle();
    issue_request(KIND_DELETE, 32'sh7fff_ffff);
  endtask

  // With equal entries only the first one is removed.
  task automatic test_duplicate_keys();
    issue_request(KIND_APPEND, 32'sd5);
    issue_request(KIND_APPEND, 32'sd5);
    issue_request(KIND_DELETE, 32'sd5);
  endtask

  // Fill the list to capacity, then append once more.
  task automatic test_fill_to_full();
    while (shadow_cnt < CAPACITY) issue_request(KIND_APPEND, random_value());
    issue_request(KIND_APPEND, $urandom);
  endtask

  // Random traffic in segments that lean toward filling, toward draining or toward neither.
  task automatic test_random_traffic(input int total);
    int sent;
    int seg_len;
    int seg_idx;
    int append_pct;
    sent = 0;
    seg_idx = 0;
    while (sent < total) begin
      seg_len = $urandom_range(40, 160);
      case (seg_idx % 3)
        0: append_pct = 85;
        1: append_pct = 50;
        default: append_pct = 15;
      endcase
      // One segment runs back to back with no idle cycles at all.
      gaps_on = (seg_idx != 4);
      for (int n = 0; n < seg_len && sent < total; n++) begin
        if ($urandom_range(99) < append_pct) issue_request(KIND_APPEND, random_value());
        else issue_request(KIND_DELETE, random_key());
        sent++;
      end
      if (seg_idx == 6) drain_results();
      seg_idx++;
    end
    gaps_on = 1'b1;
  endtask

  // Sequence the tests and report the outcome.
  initial begin
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    kind_i     = KIND_APPEND;
    value_i    = '0;
    shadow_cnt = 0;
    err_cnt    = 0;
    cycle_cnt  = 0;
    gaps_on    = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_delete_empty();
    test_delete_last_entry();
    test_append_extremes();
    test_delete_missing();
    test_delete_middle();
    test_duplicate_keys();
    test_fill_to_full();
    drain_results();
    test_random_traffic(RANDOM_ITEMS);
    drain_results();

    // Let a full delete pass worth of cycles go by for any stray result.
    repeat (2 * CAPACITY + 8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[ordered_list_append_delete_core] OK");
    end else begin
      $display("[ordered_list_append_delete_core] ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
